// ----- hw/rtl/tcce_pkg.sv -----
// ----------------------------------------------------------------------------
// tcce_pkg
// Shared types, codes and helpers of the text console cursor engine.
// ----------------------------------------------------------------------------
package tcce_pkg;

  localparam int unsigned TabStop = 8;

  localparam logic [20:0] CodeBs    = 21'd8;
  localparam logic [20:0] CodeTab   = 21'd9;
  localparam logic [20:0] CodeNl    = 21'd10;
  localparam logic [20:0] CodeCr    = 21'd13;
  localparam logic [20:0] CodeEsc   = 21'd27;
  localparam logic [20:0] CodeSpace = 21'd32;
  localparam logic [20:0] CodeAscii = 21'd128;

  localparam logic [6:0] GlyphSpace = 7'd32;
  localparam logic [6:0] GlyphSubst = 7'd63;

  typedef enum logic [1:0] {
    CMD_PUT   = 2'd0,
    CMD_SET   = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_CELL   = 2'd0,
    KIND_SCROLL = 2'd1,
    KIND_CURSOR = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    REG_COLUMNS = 2'd0,
    REG_ROWS    = 2'd1,
    REG_FIRST   = 2'd2,
    REG_LAST    = 2'd3
  } reg_e;

  typedef enum logic [3:0] {
    OP_NL,
    OP_CR,
    OP_TAB,
    OP_BS,
    OP_SPACE,
    OP_CHAR,
    OP_DROP,
    OP_SET,
    OP_CLEAR
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [6:0] glyph;
    logic [7:0] pos_col;
    logic [7:0] pos_row;
  } op_t;

  typedef struct packed {
    logic [7:0] text_columns;
    logic [7:0] text_rows;
    logic [6:0] first_glyph;
    logic [6:0] last_glyph;
  } cfg_t;

  function automatic logic [6:0] font_map(logic [6:0] c, logic [6:0] first,
                                          logic [6:0] last);
    logic [6:0] r;
    r = (c < first || c > last) ? GlyphSubst : c;
    return r;
  endfunction

endpackage

// ----- hw/rtl/tcce_front.sv -----
// ----------------------------------------------------------------------------
// tcce_front
// Accepts commands and classifies them into operations for the back end.
// ----------------------------------------------------------------------------
module tcce_front (
  input  logic            s_valid_i,
  output logic            s_ready_o,
  input  logic [1:0]      cmd_i,
  input  logic [20:0]     codepoint_i,
  input  logic [7:0]      pos_col_i,
  input  logic [7:0]      pos_row_i,
  output logic            push_o,
  output tcce_pkg::op_t   op_o,
  input  logic            full_i
);

  logic keep;

  assign s_ready_o = !full_i;

  always_comb begin
    keep             = 1'b1;
    op_o.op          = tcce_pkg::OP_DROP;
    op_o.glyph       = tcce_pkg::GlyphSpace;
    op_o.pos_col     = pos_col_i;
    op_o.pos_row     = pos_row_i;
    unique case (tcce_pkg::cmd_e'(cmd_i))
      tcce_pkg::CMD_PUT: begin
        priority if (codepoint_i == tcce_pkg::CodeNl) begin
          op_o.op = tcce_pkg::OP_NL;
        end else if (codepoint_i == tcce_pkg::CodeCr) begin
          op_o.op = tcce_pkg::OP_CR;
        end else if (codepoint_i == tcce_pkg::CodeTab) begin
          op_o.op = tcce_pkg::OP_TAB;
        end else if (codepoint_i == tcce_pkg::CodeBs) begin
          op_o.op = tcce_pkg::OP_BS;
        end else if (codepoint_i == tcce_pkg::CodeSpace) begin
          op_o.op = tcce_pkg::OP_SPACE;
        end else if (codepoint_i >= tcce_pkg::CodeSpace ||
                     codepoint_i == tcce_pkg::CodeEsc) begin
          op_o.op    = tcce_pkg::OP_CHAR;
          op_o.glyph = (codepoint_i < tcce_pkg::CodeAscii) ? codepoint_i[6:0]
                                                           : tcce_pkg::GlyphSubst;
        end else begin
          op_o.op = tcce_pkg::OP_DROP;
        end
      end
      tcce_pkg::CMD_SET:   op_o.op = tcce_pkg::OP_SET;
      tcce_pkg::CMD_CLEAR: op_o.op = tcce_pkg::OP_CLEAR;
      tcce_pkg::CMD_NONE:  keep = 1'b0;
      default:             keep = 1'b0;
    endcase
  end

  assign push_o = s_valid_i && !full_i && keep;

endmodule

// ----- hw/rtl/tcce_queue.sv -----
// ----------------------------------------------------------------------------
// tcce_queue
// Short operation queue between the front and back ends.
// ----------------------------------------------------------------------------
module tcce_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  tcce_pkg::op_t op_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output tcce_pkg::op_t op_o
);

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(Depth - 1);
  localparam logic [CntW-1:0]  Full     = CntW'(Depth);

  tcce_pkg::op_t    mem_q [Depth];
  logic [AddrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == Full);
  assign valid_o = (cnt_q != '0);
  assign op_o    = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == LastAddr) ? '0 : wr_q + AddrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == LastAddr) ? '0 : rd_q + AddrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= op_i;
    end
  end

endmodule

// ----- hw/rtl/tcce_back.sv -----
// ----------------------------------------------------------------------------
// tcce_back
// Cursor sequencer: carries out one operation, at most one result per step.
// ----------------------------------------------------------------------------
module tcce_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  tcce_pkg::cfg_t cfg_i,
  input  logic           q_valid_i,
  input  tcce_pkg::op_t  q_op_i,
  output logic           pop_o,
  output logic           m_valid_o,
  input  logic           m_ready_i,
  output logic [1:0]     kind_o,
  output logic [7:0]     col_o,
  output logic [7:0]     row_o,
  output logic [6:0]     glyph_o,
  output logic           last_o
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_WRAP = 7'b0000010,
    S_TAB  = 7'b0000100,
    S_CELL = 7'b0001000,
    S_NEXT = 7'b0010000,
    S_CURS = 7'b0100000,
    S_CLR  = 7'b1000000
  } state_e;

  state_e      state_q, state_d;
  logic [7:0]  col_q, col_d, row_q, row_d;
  logic [8:0]  stop_q, stop_d;
  logic [6:0]  glyph_q, glyph_d;
  logic        step_q, step_d, chk_q, chk_d, put_q, put_d;

  logic        out_valid_q, out_valid_d;
  logic [1:0]  kind_q;
  logic [7:0]  ocol_q, orow_q;
  logic [6:0]  oglyph_q;
  logic        olast_q;

  logic        emit, e_last;
  tcce_pkg::kind_e e_kind;
  logic [7:0]  e_col, e_row;
  logic [6:0]  e_glyph;

  logic        adv;
  logic [7:0]  cols_eff, rows_eff, rows_m1;
  logic [8:0]  row_inc, col_inc;
  logic        scroll, col_ge;

  assign adv      = !out_valid_q || m_ready_i;
  assign cols_eff = (cfg_i.text_columns == '0) ? 8'd1 : cfg_i.text_columns;
  assign rows_eff = (cfg_i.text_rows == '0) ? 8'd1 : cfg_i.text_rows;
  assign rows_m1  = rows_eff - 8'd1;
  assign row_inc  = {1'b0, row_q} + 9'd1;
  assign col_inc  = {1'b0, col_q} + 9'd1;
  assign scroll   = row_inc >= {1'b0, rows_eff};
  assign col_ge   = col_q >= cols_eff;

  always_comb begin
    state_d = state_q;
    col_d   = col_q;
    row_d   = row_q;
    stop_d  = stop_q;
    glyph_d = glyph_q;
    step_d  = step_q;
    chk_d   = chk_q;
    put_d   = put_q;
    pop_o   = 1'b0;
    emit    = 1'b0;
    e_kind  = tcce_pkg::KIND_CELL;
    e_col   = '0;
    e_row   = '0;
    e_glyph = '0;
    e_last  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (q_valid_i && adv) begin
          pop_o = 1'b1;
          unique case (q_op_i.op)
            tcce_pkg::OP_NL: state_d = S_NEXT;
            tcce_pkg::OP_CR: begin
              col_d   = '0;
              state_d = S_CURS;
            end
            tcce_pkg::OP_TAB: begin
              stop_d  = 9'(({1'b0, col_q} / tcce_pkg::TabStop + 9'd1) * tcce_pkg::TabStop);
              state_d = S_TAB;
            end
            tcce_pkg::OP_BS: begin
              glyph_d = tcce_pkg::GlyphSpace;
              step_d  = 1'b0;
              chk_d   = 1'b0;
              priority if (col_q != '0) begin
                col_d   = col_q - 8'd1;
                state_d = S_CELL;
              end else if (row_q != '0) begin
                row_d   = row_q - 8'd1;
                col_d   = cols_eff - 8'd1;
                state_d = S_CELL;
              end else begin
                state_d = S_CURS;
              end
            end
            tcce_pkg::OP_SPACE: begin
              glyph_d = tcce_pkg::GlyphSpace;
              step_d  = 1'b1;
              chk_d   = 1'b1;
              state_d = S_CELL;
            end
            tcce_pkg::OP_CHAR: begin
              glyph_d = q_op_i.glyph;
              step_d  = 1'b1;
              chk_d   = 1'b0;
              put_d   = 1'b1;
              state_d = S_WRAP;
            end
            tcce_pkg::OP_DROP: begin
              put_d   = 1'b0;
              state_d = S_WRAP;
            end
            tcce_pkg::OP_SET: begin
              col_d   = (q_op_i.pos_col > cols_eff) ? cols_eff : q_op_i.pos_col;
              row_d   = (q_op_i.pos_row > rows_m1) ? rows_m1 : q_op_i.pos_row;
              state_d = S_CURS;
            end
            tcce_pkg::OP_CLEAR: begin
              col_d   = '0;
              row_d   = '0;
              state_d = S_CLR;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_WRAP: begin
        if (adv) begin
          if (col_ge) begin
            col_d = '0;
            if (scroll) begin
              row_d  = rows_m1;
              emit   = 1'b1;
              e_kind = tcce_pkg::KIND_SCROLL;
              e_row  = rows_m1;
            end else begin
              row_d = row_inc[7:0];
            end
          end
          state_d = put_q ? S_CELL : S_CURS;
        end
      end
      S_TAB: begin
        if (adv) begin
          if ({1'b0, col_q} < stop_q && !col_ge) begin
            emit    = 1'b1;
            e_col   = col_q;
            e_row   = row_q;
            e_glyph = tcce_pkg::font_map(tcce_pkg::GlyphSpace, cfg_i.first_glyph,
                                         cfg_i.last_glyph);
            col_d   = col_inc[7:0];
          end else begin
            state_d = col_ge ? S_NEXT : S_CURS;
          end
        end
      end
      S_CELL: begin
        if (adv) begin
          emit    = 1'b1;
          e_col   = col_q;
          e_row   = row_q;
          e_glyph = tcce_pkg::font_map(glyph_q, cfg_i.first_glyph, cfg_i.last_glyph);
          if (step_q) begin
            col_d = col_inc[7:0];
          end
          state_d = (chk_q && col_inc >= {1'b0, cols_eff}) ? S_NEXT : S_CURS;
        end
      end
      S_NEXT: begin
        if (adv) begin
          col_d = '0;
          if (scroll) begin
            row_d  = rows_m1;
            emit   = 1'b1;
            e_kind = tcce_pkg::KIND_SCROLL;
            e_row  = rows_m1;
          end else begin
            row_d = row_inc[7:0];
          end
          state_d = S_CURS;
        end
      end
      S_CURS: begin
        if (adv) begin
          emit    = 1'b1;
          e_kind  = tcce_pkg::KIND_CURSOR;
          e_col   = col_q;
          e_row   = row_q;
          e_last  = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_CLR: begin
        if (adv) begin
          emit    = 1'b1;
          e_kind  = tcce_pkg::KIND_CLEAR;
          e_last  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    out_valid_d = emit ? 1'b1 : (out_valid_q && !m_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      col_q       <= '0;
      row_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      col_q       <= col_d;
      row_q       <= row_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    stop_q  <= stop_d;
    glyph_q <= glyph_d;
    step_q  <= step_d;
    chk_q   <= chk_d;
    put_q   <= put_d;
    if (emit) begin
      kind_q   <= e_kind;
      ocol_q   <= e_col;
      orow_q   <= e_row;
      oglyph_q <= e_glyph;
      olast_q  <= e_last;
    end
  end

  assign m_valid_o = out_valid_q;
  assign kind_o    = kind_q;
  assign col_o     = ocol_q;
  assign row_o     = orow_q;
  assign glyph_o   = oglyph_q;
  assign last_o    = olast_q;

endmodule

// ----- hw/rtl/text_console_cursor_engine_top.sv -----
// ----------------------------------------------------------------------------
// text_console_cursor_engine_top
// Character-cell console cursor engine: cell writes, scrolls, clears and cursor
// updates from a stream of console commands.
//
// Channel   Dir  Handshake               Content
// s_axis    in   s_axis_tvalid/tready    tuser: cmd; tdata: codepoint, pos_col, pos_row
// m_axis    out  m_axis_tvalid/tready    tuser: kind; tdata: col, row, glyph; tlast
// cfg       in   cfg_valid_i/cfg_ready_o index 0..3, 8-bit data
//
// At most one result leaves per cycle, while m_axis accepts it; a command takes
// a dispatch step plus its sequencer steps (a tab is the longest).
// The operation queue lets new commands in while the sequencer works.
// Reset homes the cursor, loads the register defaults and empties the queue.
// A stalled output holds the sequencer; a full queue holds s_axis.
// ----------------------------------------------------------------------------
module text_console_cursor_engine_top #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // codepoint[20:0], pos_col[28:21], pos_row[36:29]
  input  logic [1:0]  s_axis_tuser,   // cmd[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // col[7:0], row[15:8], glyph[22:16]
  output logic [1:0]  m_axis_tuser,   // kind[1:0]
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);

  tcce_pkg::cfg_t cfg_q;
  tcce_pkg::op_t  f_op, q_op;
  logic           push, full, q_valid, pop;
  logic [7:0]     o_col, o_row;
  logic [6:0]     o_glyph;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.text_columns <= 8'd80;
      cfg_q.text_rows    <= 8'd25;
      cfg_q.first_glyph  <= 7'd32;
      cfg_q.last_glyph   <= 7'd126;
    end else if (cfg_valid_i) begin
      unique case (tcce_pkg::reg_e'(cfg_index_i))
        tcce_pkg::REG_COLUMNS: cfg_q.text_columns <= cfg_data_i;
        tcce_pkg::REG_ROWS:    cfg_q.text_rows    <= cfg_data_i;
        tcce_pkg::REG_FIRST:   cfg_q.first_glyph  <= cfg_data_i[6:0];
        tcce_pkg::REG_LAST:    cfg_q.last_glyph   <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  tcce_front u_front (
    .s_valid_i   (s_axis_tvalid),
    .s_ready_o   (s_axis_tready),
    .cmd_i       (s_axis_tuser),
    .codepoint_i (s_axis_tdata[20:0]),
    .pos_col_i   (s_axis_tdata[28:21]),
    .pos_row_i   (s_axis_tdata[36:29]),
    .push_o      (push),
    .op_o        (f_op),
    .full_i      (full)
  );

  tcce_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .op_i    (f_op),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .op_o    (q_op)
  );

  tcce_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .q_valid_i (q_valid),
    .q_op_i    (q_op),
    .pop_o     (pop),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .kind_o    (m_axis_tuser),
    .col_o     (o_col),
    .row_o     (o_row),
    .glyph_o   (o_glyph),
    .last_o    (m_axis_tlast)
  );

  assign m_axis_tdata = {1'b0, o_glyph, o_row, o_col};

endmodule
